// ===== design/bibox_pkg.sv =====
// Shared types, constants and helper functions for the rotating-box ball step block.
// Used by the multiplier, the sequencer and the top level.
// Depends on nothing.
package bibox_pkg;

   localparam int FRAC  = 16;
   localparam int A_W   = 48;
   localparam int B_W   = 32;
   localparam int P_W   = 64;
   localparam int LO_W  = 17;
   localparam int HI_W  = B_W - LO_W;
   localparam int D_W   = LO_W + 1;
   localparam int C_W   = 38;
   localparam int H_W   = C_W - 1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTITUTION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRICTION    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RADIUS  = 3'd4;

   localparam logic signed [31:0] GRAVITY_RST     = -32'sd642908;
   localparam logic [16:0]        RESTITUTION_RST = 17'd55706;
   localparam logic [16:0]        FRICTION_RST    = 17'd655;
   localparam logic [30:0]        WALL_LIMIT_RST  = 31'd319816;
   localparam logic [30:0]        INV_RADIUS_RST  = 31'd546133;
   localparam logic [16:0]        Q_ONE           = 17'd65536;

   typedef struct packed {
      logic signed [31:0] gravity;
      logic [16:0]        restitution;
      logic [16:0]        friction;
      logic [30:0]        wall_limit;
      logic [30:0]        inverse_radius;
   } cfg_type;

   typedef struct packed {
      logic               mode;
      logic [15:0]        time_step;
      logic signed [20:0] rate_x;
      logic signed [20:0] rate_z;
      logic signed [31:0] load_px;
      logic signed [31:0] load_py;
      logic signed [31:0] load_pz;
      logic signed [31:0] load_vx;
      logic signed [31:0] load_vy;
      logic signed [31:0] load_vz;
   } item_type;

   // packed so that out_px lands in the lowest bits
   typedef struct packed {
      logic signed [31:0] spin_z;
      logic signed [31:0] spin_x;
      logic signed [31:0] pz;
      logic signed [31:0] py;
      logic signed [31:0] px;
   } result_type;

   typedef struct packed {
      logic                  go;
      logic                  wide;
      logic signed [A_W-1:0] a;
      logic signed [B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                  fin;
      logic                  first;
      logic signed [P_W-1:0] prod;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GRAV,
      ST_CORI,
      ST_CORI_DT,
      ST_CEN_PX,
      ST_CEN_PZ,
      ST_CEN_X,
      ST_CEN_X_DT,
      ST_CEN_Z,
      ST_CEN_Z_DT,
      ST_KEEP_X,
      ST_KEEP_Y,
      ST_KEEP_Z,
      ST_MOVE,
      ST_WALL,
      ST_BOUNCE,
      ST_SPIN_X,
      ST_SPIN_X_DT,
      ST_SPIN_Z,
      ST_SPIN_Z_DT,
      ST_SPIN_END,
      ST_FIN
   } seq_state_type;

   function automatic logic [16:0] coef_clip(input logic [16:0] c);
      return (c > Q_ONE) ? Q_ONE : c;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (x < 64'shFFFF_FFFF_8000_0000) begin
         return 32'sh8000_0000;
      end
      return signed'(x[31:0]);
   endfunction

endpackage

// ===== design/bibox_mul.sv =====
// Shared signed multiplier: 48-bit operand times a 32-bit operand taken as a
// 17-bit low and a 15-bit high digit; only wide ones get a high-digit pass.
// Depends on bibox_pkg.
module bibox_mul import bibox_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic                          phase_ff, phase_in;
   logic signed [A_W-1:0]         a_hold_ff;
   logic signed [HI_W-1:0]        hi_hold_ff;
   logic signed [P_W-1:0]         acc_ff, acc_in;
   logic signed [A_W-1:0]         m_a;
   logic signed [D_W-1:0]         m_b;
   logic signed [A_W+D_W-1:0]     m_p;

   always_comb begin
      if (phase_ff) begin
         m_a = a_hold_ff;
         m_b = D_W'(hi_hold_ff);
      end else begin
         m_a = req.a;
         m_b = signed'({1'b0, req.b[LO_W-1:0]});
      end
      m_p = m_a * m_b;
      if (phase_ff) begin
         acc_in = acc_ff + signed'({m_p[P_W-LO_W-1:0], {LO_W{1'b0}}});
      end else begin
         acc_in = signed'(m_p[P_W-1:0]);
      end
      phase_in  = req.go && req.wide && !phase_ff;
      rsp.fin   = req.go && (!req.wide || phase_ff);
      rsp.first = !phase_ff;
      rsp.prod  = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.go) begin
         acc_ff <= acc_in;
      end
      if (!phase_ff) begin
         a_hold_ff  <= req.a;
         hi_hold_ff <= signed'(req.b[B_W-1:LO_W]);
      end
   end

endmodule

// ===== design/bibox_seq.sv =====
// Step sequencer and ball state: walks one item through the shared multiplier,
// consuming each product in the cycle after it completes.
// Depends on bibox_pkg; drives bibox_mul.
module bibox_seq import bibox_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  item_type    item,
   input  cfg_type     cfg,
   input  logic        out_free,
   output logic        idle,
   output logic        done,
   output result_type  result,
   output mul_req_type mreq,
   input  mul_rsp_type mrsp
);

   seq_state_type        state_ff, state_in;
   logic [1:0]           ax_ff, ax_in;
   logic signed [31:0]   pos_ff [3];
   logic signed [31:0]   pos_in [3];
   logic signed [31:0]   vel_ff [3];
   logic signed [31:0]   vel_in [3];
   logic signed [31:0]   spin_ff [2];
   logic signed [31:0]   spin_in [2];
   logic signed [H_W-1:0] h_ff, h_in;
   logic signed [C_W-1:0] c_ff, c_in;
   logic [15:0]          dt_ff, dt_in;
   logic signed [20:0]   wx_ff, wx_in;
   logic signed [20:0]   wz_ff, wz_in;

   logic signed [P_W-1:0] prod, sh16, sh15;
   logic signed [A_W-1:0] prod_a;
   logic signed [31:0]    vy_new;
   logic signed [C_W-1:0] c_new;
   logic signed [31:0]    vel_sel, pos_sel;
   logic signed [63:0]    p_sum, wall64;
   logic                  hit_hi, hit_lo;
   logic [16:0]           keep, bounce;
   logic signed [B_W-1:0] b_dt, b_wx, b_wz, b_keep, b_bounce, b_invr;

   assign prod     = mrsp.prod;
   assign sh16     = prod >>> FRAC;
   assign sh15     = prod >>> (FRAC - 1);
   assign prod_a   = signed'(prod[P_W-1:FRAC]);
   assign vy_new   = sat32(64'(vel_ff[1]) + sh16);
   assign c_new    = C_W'(h_ff) - signed'(prod[FRAC+C_W-1:FRAC]);
   assign vel_sel  = vel_ff[ax_ff];
   assign pos_sel  = pos_ff[ax_ff];
   assign p_sum    = 64'(pos_sel) + sh16;
   assign wall64   = signed'(64'(cfg.wall_limit));
   assign hit_hi   = p_sum > wall64;
   assign hit_lo   = p_sum < -wall64;
   assign keep     = Q_ONE - coef_clip(cfg.friction);
   assign bounce   = coef_clip(cfg.restitution);
   assign b_dt     = signed'(B_W'(dt_ff));
   assign b_wx     = B_W'(wx_ff);
   assign b_wz     = B_W'(wz_ff);
   assign b_keep   = signed'(B_W'(keep));
   assign b_bounce = signed'(B_W'(bounce));
   assign b_invr   = signed'(B_W'(cfg.inverse_radius));

   assign idle      = (state_ff == ST_IDLE);
   assign result.px = pos_ff[0];
   assign result.py = pos_ff[1];
   assign result.pz = pos_ff[2];
   assign result.spin_x = spin_ff[0];
   assign result.spin_z = spin_ff[1];

   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      spin_in  = spin_ff;
      h_in     = h_ff;
      c_in     = c_ff;
      dt_in    = dt_ff;
      wx_in    = wx_ff;
      wz_in    = wz_ff;
      mreq     = '0;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (item.mode) begin
                  pos_in  = '{item.load_px, item.load_py, item.load_pz};
                  vel_in  = '{item.load_vx, item.load_vy, item.load_vz};
                  spin_in = '{32'sd0, 32'sd0};
                  state_in = ST_FIN;
               end else begin
                  dt_in    = item.time_step;
                  wx_in    = item.rate_x;
                  wz_in    = item.rate_z;
                  ax_in    = 2'd0;
                  state_in = ST_GRAV;
               end
            end
         end
         ST_GRAV: begin
            mreq = '{go: 1'b1, wide: 1'b0, a: A_W'(cfg.gravity), b: b_dt};
            state_in = ST_CORI;
         end
         ST_CORI: begin
            if (mrsp.first) begin
               vel_in[1] = vy_new;
            end
            mreq = '{go: 1'b1, wide: 1'b1, a: A_W'(vy_new), b: b_wx};
            if (mrsp.fin) begin
               state_in = ST_CORI_DT;
            end
         end
         ST_CORI_DT: begin
            mreq = '{go: 1'b1, wide: 1'b0, a: prod_a, b: b_dt};
            state_in = ST_CEN_PX;
         end
         ST_CEN_PX: begin
            if (mrsp.first) begin
               vel_in[2] = sat32(64'(vel_ff[2]) + sh15);
            end
            mreq = '{go: 1'b1, wide: 1'b1, a: A_W'(pos_ff[0]), b: b_wz};
            if (mrsp.fin) begin
               state_in = ST_CEN_PZ;
            end
         end
         ST_CEN_PZ: begin
            if (mrsp.first) begin
               h_in = signed'(prod[FRAC+H_W-1:FRAC]);
            end
            mreq = '{go: 1'b1, wide: 1'b1, a: A_W'(pos_ff[2]), b: b_wx};
            if (mrsp.fin) begin
               state_in = ST_CEN_X;
            end
         end
         ST_CEN_X: begin
            if (mrsp.first) begin
               c_in = c_new;
            end
            mreq = '{go: 1'b1, wide: 1'b1, a: A_W'(c_new), b: b_wz};
            if (mrsp.fin) begin
               state_in = ST_CEN_X_DT;
            end
         end
         ST_CEN_X_DT: begin
            mreq = '{go: 1'b1, wide: 1'b0, a: prod_a, b: b_dt};
            state_in = ST_CEN_Z;
         end
         ST_CEN_Z: begin
            if (mrsp.first) begin
               vel_in[0] = sat32(64'(vel_ff[0]) + sh16);
            end
            mreq = '{go: 1'b1, wide: 1'b1, a: A_W'(c_ff), b: b_wx};
            if (mrsp.fin) begin
               state_in = ST_CEN_Z_DT;
            end
         end
         ST_CEN_Z_DT: begin
            mreq = '{go: 1'b1, wide: 1'b0, a: prod_a, b: b_dt};
            state_in = ST_KEEP_X;
         end
         ST_KEEP_X: begin
            vel_in[2] = sat32(64'(vel_ff[2]) + sh16);
            mreq = '{go: 1'b1, wide: 1'b0, a: A_W'(vel_ff[0]), b: b_keep};
            state_in = ST_KEEP_Y;
         end
         ST_KEEP_Y: begin
            vel_in[0] = sat32(sh16);
            mreq = '{go: 1'b1, wide: 1'b0, a: A_W'(vel_ff[1]), b: b_keep};
            state_in = ST_KEEP_Z;
         end
         ST_KEEP_Z: begin
            vel_in[1] = sat32(sh16);
            mreq = '{go: 1'b1, wide: 1'b0, a: A_W'(vel_ff[2]), b: b_keep};
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            // first axis also retires the z friction product
            if (ax_ff == 2'd0) begin
               vel_in[2] = sat32(sh16);
            end
            mreq = '{go: 1'b1, wide: 1'b0, a: A_W'(vel_sel), b: b_dt};
            state_in = ST_WALL;
         end
         ST_WALL: begin
            if (hit_hi || hit_lo) begin
               pos_in[ax_ff] = hit_hi ? wall64[31:0] : 32'(-wall64);
               mreq = '{go: 1'b1, wide: 1'b0, a: -A_W'(vel_sel), b: b_bounce};
               state_in = ST_BOUNCE;
            end else begin
               pos_in[ax_ff] = p_sum[31:0];
               if (ax_ff == 2'd2) begin
                  state_in = ST_SPIN_X;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_MOVE;
               end
            end
         end
         ST_BOUNCE: begin
            vel_in[ax_ff] = sat32(sh16);
            if (ax_ff == 2'd2) begin
               state_in = ST_SPIN_X;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_MOVE;
            end
         end
         ST_SPIN_X: begin
            mreq = '{go: 1'b1, wide: 1'b1, a: -A_W'(vel_ff[2]), b: b_invr};
            if (mrsp.fin) begin
               state_in = ST_SPIN_X_DT;
            end
         end
         ST_SPIN_X_DT: begin
            mreq = '{go: 1'b1, wide: 1'b0, a: prod_a, b: b_dt};
            state_in = ST_SPIN_Z;
         end
         ST_SPIN_Z: begin
            if (mrsp.first) begin
               spin_in[0] = sat32(64'(spin_ff[0]) + sh16);
            end
            mreq = '{go: 1'b1, wide: 1'b1, a: A_W'(vel_ff[0]), b: b_invr};
            if (mrsp.fin) begin
               state_in = ST_SPIN_Z_DT;
            end
         end
         ST_SPIN_Z_DT: begin
            mreq = '{go: 1'b1, wide: 1'b0, a: prod_a, b: b_dt};
            state_in = ST_SPIN_END;
         end
         ST_SPIN_END: begin
            spin_in[1] = sat32(64'(spin_ff[1]) + sh16);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ax_ff    <= 2'd0;
         pos_ff   <= '{32'sd0, 32'sd0, 32'sd0};
         vel_ff   <= '{32'sd0, 32'sd0, 32'sd0};
         spin_ff  <= '{32'sd0, 32'sd0};
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         spin_ff  <= spin_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff  <= h_in;
      c_ff  <= c_in;
      dt_ff <= dt_in;
      wx_ff <= wx_in;
      wz_ff <= wz_in;
   end

endmodule

// ===== design/ball_in_rotating_box_step_top.sv =====
// Ball in rotating box step: a load transaction passes through the final state into the
// output register; a step runs 19 products (7 two-pass) and 1 per wall bounce
// on one shared 48x18 multiplier, 3 wall tests, spin write-back and handoff.
// The next transaction can be taken in the same cycle that rsp_tvalid rises; the result
// sits in an output register, so that transaction may start while it waits.
// Reset (synchronous, active high) zeroes the ball state and restores register defaults.
module ball_in_rotating_box_step_top import bibox_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // time_step[15:0], rate_x[36:16], rate_z[57:37], load_px[89:58], load_py[121:90],
   // load_pz[153:122], load_vx[185:154], load_vy[217:186], load_vz[249:218], zero fill
   input  logic [255:0]         req_tdata,
   // mode[0]
   input  logic [0:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // out_px[31:0], out_py[63:32], out_pz[95:64], out_spin_x[127:96], out_spin_z[159:128]
   output logic [159:0]         rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;
   item_type    item;
   result_type  result;
   logic        seq_idle, seq_done, out_free, start;
   mul_req_type mreq;
   mul_rsp_type mrsp;

   assign item.mode      = req_tuser[0];
   assign item.time_step = req_tdata[15:0];
   assign item.rate_x    = signed'(req_tdata[36:16]);
   assign item.rate_z    = signed'(req_tdata[57:37]);
   assign item.load_px   = signed'(req_tdata[89:58]);
   assign item.load_py   = signed'(req_tdata[121:90]);
   assign item.load_pz   = signed'(req_tdata[153:122]);
   assign item.load_vx   = signed'(req_tdata[185:154]);
   assign item.load_vy   = signed'(req_tdata[217:186]);
   assign item.load_vz   = signed'(req_tdata[249:218]);

   assign req_tready = seq_idle;
   assign start      = req_tvalid && seq_idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GRAVITY:     cfg_in.gravity        = signed'(csr_wdata);
            CSR_RESTITUTION: cfg_in.restitution    = csr_wdata[16:0];
            CSR_FRICTION:    cfg_in.friction       = csr_wdata[16:0];
            CSR_WALL_LIMIT:  cfg_in.wall_limit     = csr_wdata[30:0];
            CSR_INV_RADIUS:  cfg_in.inverse_radius = csr_wdata[30:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
      if (seq_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity        <= GRAVITY_RST;
         cfg_ff.restitution    <= RESTITUTION_RST;
         cfg_ff.friction       <= FRICTION_RST;
         cfg_ff.wall_limit     <= WALL_LIMIT_RST;
         cfg_ff.inverse_radius <= INV_RADIUS_RST;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_data_ff <= result;
      end
   end

   bibox_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .idle     (seq_idle),
      .done     (seq_done),
      .result   (result),
      .mreq     (mreq),
      .mrsp     (mrsp)
   );

   bibox_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

endmodule

// ===== design/bibox_checker.sv =====
// Port-level checks for the rotating-box ball step block, bound to the top level.
// Sees the top-level ports only; no package dependency.
module bibox_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [255:0] req_tdata,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [159:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready while a transaction is in work");

   a_ready_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result shown but sequencer not back to idle");

   a_load_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] && !rsp_tvalid |=> ##1
         (rsp_tvalid && rsp_tdata[31:0] == $past(req_tdata[89:58], 2) &&
          rsp_tdata[63:32] == $past(req_tdata[121:90], 2) &&
          rsp_tdata[159:96] == 64'd0))
      else $error("load transaction result wrong or late");

endmodule

bind ball_in_rotating_box_step_top bibox_checker u_bibox_checker (.*);

// ===== dv/ball_step_checker.sv =====
// Checker for the rotating-box ball step block: watches the csr, req and rsp channels,
// keeps its own copy of the registers and the ball state, and compares each rsp transaction.
// Depends on bibox_pkg for the register indexes, reset values and result layout.
`timescale 1ns / 1ps
module ball_step_checker import bibox_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [255:0]         req_tdata,
   input  logic [0:0]           req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [159:0]         rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   mismatches,
   output int                   awaiting,
   output int                   wall_hits
);

   cfg_type            cfg;
   logic signed [31:0] pos [3];
   logic signed [31:0] vel [3];
   logic signed [31:0] spin [2];
   result_type         ball_q [$];

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   // one time step; every rescale is a floor shift, as the datapath does it
   function automatic void step_ball(input logic [15:0] dt_u,
                                     input logic signed [20:0] rx,
                                     input logic signed [20:0] rz);
      longint dt, wx, wz, px, pz, c, keep, bounce, lim, ir, p;
      dt = longint'(dt_u);
      wx = longint'(rx);
      wz = longint'(rz);
      px = longint'(pos[0]);
      pz = longint'(pos[2]);
      ir = longint'(cfg.inverse_radius);

      vel[1] = clamp32(longint'(vel[1]) + ((longint'(cfg.gravity) * dt) >>> 16));
      vel[2] = clamp32(longint'(vel[2]) + ((((wx * longint'(vel[1])) >>> 16) * dt) >>> 15));

      c = ((wz * px) >>> 16) - ((wx * pz) >>> 16);
      vel[0] = clamp32(longint'(vel[0]) + ((((wz * c) >>> 16) * dt) >>> 16));
      vel[2] = clamp32(longint'(vel[2]) + ((((wx * c) >>> 16) * dt) >>> 16));

      keep = longint'(Q_ONE) -
             ((cfg.friction > Q_ONE) ? longint'(Q_ONE) : longint'(cfg.friction));
      for (int i = 0; i < 3; i++) begin
         vel[i] = clamp32((longint'(vel[i]) * keep) >>> 16);
      end

      bounce = (cfg.restitution > Q_ONE) ? longint'(Q_ONE) : longint'(cfg.restitution);
      lim = longint'(cfg.wall_limit);
      for (int i = 0; i < 3; i++) begin
         p = longint'(pos[i]) + ((longint'(vel[i]) * dt) >>> 16);
         if (p > lim || p < -lim) begin
            p = (p > lim) ? lim : -lim;
            vel[i] = clamp32((-longint'(vel[i]) * bounce) >>> 16);
            wall_hits++;
         end
         pos[i] = p[31:0];
      end

      spin[0] = clamp32(longint'(spin[0]) +
                        ((((-longint'(vel[2]) * ir) >>> 16) * dt) >>> 16));
      spin[1] = clamp32(longint'(spin[1]) +
                        ((((longint'(vel[0]) * ir) >>> 16) * dt) >>> 16));
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         $error("rsp %s: expected %0d, got %0d", name, $signed(want), $signed(seen));
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         cfg = '{gravity: GRAVITY_RST, restitution: RESTITUTION_RST, friction: FRICTION_RST,
                 wall_limit: WALL_LIMIT_RST, inverse_radius: INV_RADIUS_RST};
         for (int i = 0; i < 3; i++) begin
            pos[i] = '0;
            vel[i] = '0;
         end
         spin[0] = '0;
         spin[1] = '0;
         ball_q.delete();
         mismatches = 0;
         wall_hits = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRAVITY:     cfg.gravity        = csr_wdata;
               CSR_RESTITUTION: cfg.restitution    = csr_wdata[16:0];
               CSR_FRICTION:    cfg.friction       = csr_wdata[16:0];
               CSR_WALL_LIMIT:  cfg.wall_limit     = csr_wdata[30:0];
               CSR_INV_RADIUS:  cfg.inverse_radius = csr_wdata[30:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (ball_q.size() == 0) begin
               $error("rsp transaction with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = ball_q.pop_front();
               check_field("out_px", want.px, got.px);
               check_field("out_py", want.py, got.py);
               check_field("out_pz", want.pz, got.pz);
               check_field("out_spin_x", want.spin_x, got.spin_x);
               check_field("out_spin_z", want.spin_z, got.spin_z);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0]) begin
               pos[0] = req_tdata[89:58];
               pos[1] = req_tdata[121:90];
               pos[2] = req_tdata[153:122];
               vel[0] = req_tdata[185:154];
               vel[1] = req_tdata[217:186];
               vel[2] = req_tdata[249:218];
               spin[0] = '0;
               spin[1] = '0;
            end else begin
               step_ball(req_tdata[15:0], req_tdata[36:16], req_tdata[57:37]);
            end
            ball_q.push_back('{spin_z: spin[1], spin_x: spin[0],
                               pz: pos[2], py: pos[1], px: pos[0]});
         end
      end
      awaiting = ball_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for ball_in_rotating_box_step_top: clock, reset, register settings,
// directed and random load/step transactions with random stalls, and the verdict.
// Depends on bibox_pkg, the block and ball_step_checker.
`timescale 1ns / 1ps
module tb_top import bibox_pkg::*; ();

   localparam logic MODE_STEP = 1'b0;
   localparam logic MODE_LOAD = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_INDEX = '1;
   localparam logic signed [20:0] RATE_MAX = 21'sh0F_FFFF;
   localparam logic signed [20:0] RATE_MIN = 21'sh10_0000;
   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;
   localparam int unsigned RUN_LIMIT_NS = 5_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [255:0]         req_tdata = '0;
   logic [0:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [159:0]         rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   int         mismatches, awaiting, wall_hits;
   int         n_loads, n_steps, n_writes;
   int         rsp_hold;
   bit         quiet = 1'b0;
   bit         calm_end = 1'b0;
   logic [30:0] wall_now = WALL_LIMIT_RST;

   ball_in_rotating_box_step_top dut (.*);

   ball_step_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [31:0] near(input longint mag);
      longint pick;
      pick = longint'($urandom_range(32'(2 * mag), 0)) - mag;
      return pick[31:0];
   endfunction

   function automatic logic [31:0] spot();
      longint span;
      span = (wall_now > 31'd1073741823) ? 64'sd1073741823 :
             longint'(wall_now) + longint'(wall_now) / 4 + 1;
      if ($urandom_range(0, 7) == 0) return $urandom;
      return near(span);
   endfunction

   function automatic logic [31:0] speed();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return near(64'sd1 << 20);
   endfunction

   function automatic logic [20:0] rate();
      if ($urandom_range(0, 7) == 0) return 21'($urandom);
      return 21'(near(64'sd1 << 17));
   endfunction

   function automatic logic [15:0] step_len();
      case ($urandom_range(0, 15))
         0:       return '0;
         1, 2:    return 16'($urandom);
         default: return 16'($urandom_range(1, 3000));
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the handshake
   task automatic put_item(input logic mode, input logic [15:0] dt,
                           input logic [20:0] wx, input logic [20:0] wz,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [31:0] vx,
                           input logic [31:0] vy, input logic [31:0] vz);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, vz, vy, vx, pz, py, px, wz, wx, dt};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (mode == MODE_LOAD) n_loads++;
      else n_steps++;
   endtask

   task automatic send_load(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz, input logic [31:0] vx,
                            input logic [31:0] vy, input logic [31:0] vz);
      put_item(MODE_LOAD, 16'($urandom), 21'($urandom), 21'($urandom),
               px, py, pz, vx, vy, vz);
   endtask

   task automatic send_step(input logic [15:0] dt, input logic [20:0] wx,
                            input logic [20:0] wz);
      put_item(MODE_STEP, dt, wx, wz, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      n_writes++;
   endtask

   // registers only change with nothing in flight
   task automatic apply_setting(input logic [31:0] grav, input logic [31:0] rest,
                                input logic [31:0] fric, input logic [31:0] wall,
                                input logic [31:0] inv_r);
      drain();
      write_reg(CSR_GRAVITY, grav);
      write_reg(CSR_RESTITUTION, rest);
      write_reg(CSR_FRICTION, fric);
      write_reg(CSR_WALL_LIMIT, wall);
      write_reg(CSR_INV_RADIUS, inv_r);
      write_reg(CSR_IDX_W'($urandom_range(CSR_INV_RADIUS + 1, CSR_TOP_INDEX)), $urandom);
      csr_valid <= 1'b0;
      wall_now = wall[30:0];
   endtask

   // mostly a load followed by a run of steps; some runs skip the load, some noise
   task automatic run_phase(input int items);
      int left, burst;
      left = items;
      while (left > 0) begin
         if (!calm_end) quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            put_item(1'($urandom_range(0, 1)), 16'($urandom), 21'($urandom),
                     21'($urandom), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
            left--;
         end else begin
            if ($urandom_range(0, 4) != 0) begin
               send_load(spot(), spot(), spot(), speed(), speed(), speed());
               left--;
            end
            burst = $urandom_range(1, 15);
            for (int i = 0; i < burst && left > 0; i++) begin
               send_step(step_len(), rate(), rate());
               left--;
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values of the registers
      send_step(16'hFFFF, '0, '0);
      send_step('0, RATE_MAX, RATE_MIN);
      send_load('0, '0, '0, '0, '0, '0);
      send_load(S32_MAX, S32_MIN, '0, S32_MAX, S32_MIN, S32_MAX);
      send_step(16'hFFFF, RATE_MAX, RATE_MAX);
      send_step(16'hFFFF, RATE_MIN, RATE_MIN);
      send_load(32'd300000, -32'sd300000, 32'd100000, '0, S32_MIN, '0);
      send_step(16'hFFFF, '0, '0);
      send_load(32'd200000, '0, -32'sd200000, '0, '0, '0);
      send_step(16'd1000, RATE_MAX, RATE_MIN);
      send_step(16'd1000, 21'sd65536, -21'sd65536);
      send_load('0, '0, '0, '0, 32'd327680, '0);
      send_step(16'd655, 21'sd131072, '0);
      // sitting exactly on the wall, then crossing it
      send_load(32'd319816, -32'sd319816, '0, 32'd65536, -32'sd65536, '0);
      send_step(16'd1, '0, '0);
      send_step(16'h0100, '0, '0);
      run_phase(200);

      // upper extremes, restitution above one, no friction
      apply_setting(S32_MAX, 32'h0001_FFFF, '0, S32_MAX, S32_MAX);
      send_load(S32_MIN, '0, '0, S32_MIN, '0, '0);
      send_step(16'hFFFF, '0, '0);
      run_phase(200);

      // lower extremes, friction above one
      apply_setting(S32_MIN, '0, 32'h0001_FFFF, '0, '0);
      run_phase(150);

      repeat (3) begin
         apply_setting(($urandom_range(0, 3) == 0) ? $urandom : near(64'sd1 << 21),
                       ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, Q_ONE),
                       ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2000),
                       ($urandom_range(0, 5) == 0) ? $urandom :
                          $urandom_range(1 << 14, 1 << 22),
                       ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 1 << 21));
         run_phase(200);
      end

      apply_setting(GRAVITY_RST, RESTITUTION_RST, FRICTION_RST, WALL_LIMIT_RST,
                    INV_RADIUS_RST);
      calm_end = 1'b1;
      quiet = 1'b1;
      run_phase(200);

      drain();
      repeat (40) @(posedge clock);
      $display("tb_top: %0d loads and %0d steps checked, %0d register writes, %0d wall contacts",
               n_loads, n_steps, n_writes, wall_hits);
      $display("tb_top: settings swept: reset values, both extremes, three random sets");
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb_top: timeout with %0d transactions outstanding", awaiting);
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
